[sv/es2c_pkg.sv]
// shared types, constants and helper functions for the epoch seconds to calendar block
// no dependencies; imported by es2c_ctrl, es2c_dpath and epoch_seconds_to_calendar
package es2c_pkg;

  localparam logic [31:0] LAST_SECOND   = 32'd4102444799;
  localparam logic [11:0] FIRST_YEAR    = 12'd1970;
  localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;    // 1970-01-01 was a thursday
  localparam logic [3:0]  LAST_MONTH    = 4'd11;   // december, zero based

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;

  // quotients by reciprocal multiplication, exact over the operand ranges used
  // day:    ((x >> 7) * DAY_RECIP) >> 35  = x / 86400 for any 32-bit x
  // hour:   ((x >> 4) * HOUR_RECIP) >> 21 = x / 3600  for x < 2^17
  // minute: ((x >> 2) * MIN_RECIP) >> 14  = x / 60    for x < 2^12
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;

  typedef enum logic [1:0] {
    UNIT_DAY  = 2'd0,
    UNIT_HOUR = 2'd1,
    UNIT_MIN  = 2'd2
  } div_unit_e;

  typedef struct packed {
    logic      load_sum;
    logic      range_check;
    logic      quot_step;
    logic      rem_step;
    div_unit_e unit_sel;
    logic      year_step;
    logic      month_step;
    logic      publish;
  } es2c_cmd_t;

  typedef struct packed {
    logic out_of_range;
    logic year_fits;
    logic month_fits;
  } es2c_sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // weekday plus a small step, wrapped to 0..6
  function automatic logic [2:0] wd_add(input logic [2:0] wd, input logic [1:0] inc);
    logic [3:0] s;
    s = {1'b0, wd} + {2'b00, inc};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  // reduce a value below 42 modulo 7
  function automatic logic [2:0] mod7(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    for (int i = 0; i < 5; i++) begin
      if (r >= 6'd7) begin
        r = r - 6'd7;
      end
    end
    return r[2:0];
  endfunction

endpackage

[sv/es2c_ctrl.sv]
// sequencing state machine for the epoch seconds to calendar block
// depends on es2c_pkg; drives es2c_dpath through command and status structs
module es2c_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  es2c_pkg::es2c_sts_t sts_i,
  output es2c_pkg::es2c_cmd_t cmd_o
);
  import es2c_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CHECK  = 8'b0000_0010,
    ST_DAYS   = 8'b0000_0100,
    ST_HOUR   = 8'b0000_1000,
    ST_MINUTE = 8'b0001_0000,
    ST_YEAR   = 8'b0010_0000,
    ST_MONTH  = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   phase_q, phase_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    // output slot frees up when the pending result is transferred
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o       = '0;
    cmd_o.unit_sel = UNIT_DAY;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_sum = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.range_check = 1'b1;
        if (sts_i.out_of_range) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_DAYS;
        end
      end
      // each split: quotient first, then remainder
      ST_DAYS: begin
        cmd_o.unit_sel = UNIT_DAY;
        if (!phase_q) begin
          cmd_o.quot_step = 1'b1;
          phase_d         = 1'b1;
        end else begin
          cmd_o.rem_step = 1'b1;
          phase_d        = 1'b0;
          state_d        = ST_HOUR;
        end
      end
      ST_HOUR: begin
        cmd_o.unit_sel = UNIT_HOUR;
        if (!phase_q) begin
          cmd_o.quot_step = 1'b1;
          phase_d         = 1'b1;
        end else begin
          cmd_o.rem_step = 1'b1;
          phase_d        = 1'b0;
          state_d        = ST_MINUTE;
        end
      end
      ST_MINUTE: begin
        cmd_o.unit_sel = UNIT_MIN;
        if (!phase_q) begin
          cmd_o.quot_step = 1'b1;
          phase_d         = 1'b1;
        end else begin
          cmd_o.rem_step = 1'b1;
          phase_d        = 1'b0;
          state_d        = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (sts_i.year_fits) begin
          state_d = ST_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (sts_i.month_fits) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[sv/es2c_dpath.sv]
// datapath: reference register, reciprocal-multiply time splitter, year and month walkers,
// result register; depends on es2c_pkg; controlled by es2c_ctrl
module es2c_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_data_i,
  input  logic [31:0]       counter_value_i,
  input  es2c_pkg::es2c_cmd_t cmd_i,
  output es2c_pkg::es2c_sts_t sts_o,
  output logic [11:0]       year_o,
  output logic [3:0]        month_o,
  output logic [4:0]        date_o,
  output logic [4:0]        hour_o,
  output logic [5:0]        minute_o,
  output logic [5:0]        second_o,
  output logic [2:0]        weekday_o,
  output logic              out_of_range_o
);
  import es2c_pkg::*;

  logic [31:0] ref_q;
  logic [31:0] rem_q;
  logic [15:0] days_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [2:0]  wd_q;
  logic        oor_q;

  logic        leap;
  logic [8:0]  year_len;
  logic [4:0]  mlen;
  logic [50:0] day_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;

  // years reachable here are 1970..2099, where the only century year (2000) is leap
  assign leap     = (year_q[1:0] == 2'b00);
  assign year_len = leap ? 9'd366 : 9'd365;
  assign mlen     = month_len(month_q, leap);

  assign day_prod  = {26'd0, rem_q[31:7]} * {25'd0, DAY_RECIP};
  assign hour_prod = {14'd0, rem_q[16:4]} * {13'd0, HOUR_RECIP};
  assign min_prod  = {11'd0, rem_q[11:2]} * {10'd0, MIN_RECIP};

  assign sts_o.out_of_range = (rem_q > LAST_SECOND);
  assign sts_o.year_fits    = (days_q < {7'd0, year_len});
  assign sts_o.month_fits   = (days_q < {11'd0, mlen}) || (month_q == LAST_MONTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else if (cfg_we_i) begin
      ref_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.range_check) begin
      oor_q <= sts_o.out_of_range;
    end

    if (cmd_i.load_sum) begin
      rem_q    <= ref_q + counter_value_i;
      days_q   <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      year_q   <= FIRST_YEAR;
      month_q  <= '0;
      wd_q     <= EPOCH_WEEKDAY;
    end else if (cmd_i.quot_step) begin
      unique case (cmd_i.unit_sel)
        UNIT_DAY:  days_q   <= day_prod[50:35];
        UNIT_HOUR: hour_q   <= hour_prod[25:21];
        UNIT_MIN:  minute_q <= min_prod[19:14];
        default:   days_q   <= days_q;
      endcase
    end else if (cmd_i.rem_step) begin
      unique case (cmd_i.unit_sel)
        UNIT_DAY:  rem_q <= rem_q - ({16'd0, days_q} * SECS_PER_DAY);
        UNIT_HOUR: rem_q <= rem_q - ({27'd0, hour_q} * SECS_PER_HOUR);
        UNIT_MIN:  rem_q <= rem_q - ({26'd0, minute_q} * SECS_PER_MIN);
        default:   rem_q <= rem_q;
      endcase
    end else if (cmd_i.year_step) begin
      days_q <= days_q - {7'd0, year_len};
      year_q <= year_q + 12'd1;
      // 365 days move the weekday by one, 366 by two
      wd_q   <= wd_add(wd_q, leap ? 2'd2 : 2'd1);
    end else if (cmd_i.month_step) begin
      days_q  <= days_q - {11'd0, mlen};
      month_q <= month_q + 4'd1;
      wd_q    <= wd_add(wd_q, mlen[1:0]);
    end

    if (cmd_i.publish) begin
      if (oor_q) begin
        year_o         <= '0;
        month_o        <= '0;
        date_o         <= '0;
        hour_o         <= '0;
        minute_o       <= '0;
        second_o       <= '0;
        weekday_o      <= '0;
        out_of_range_o <= 1'b1;
      end else begin
        year_o         <= year_q;
        month_o        <= month_q + 4'd1;
        date_o         <= days_q[4:0] + 5'd1;
        hour_o         <= hour_q;
        minute_o       <= minute_q;
        second_o       <= rem_q[5:0];
        weekday_o      <= mod7({3'd0, wd_q} + {1'b0, days_q[4:0]});
        out_of_range_o <= 1'b0;
      end
    end
  end

endmodule

[sv/epoch_seconds_to_calendar.sv]
// converts reference plus counter seconds to gregorian date, time of day and weekday
// each item is range checked, split into days, hours and minutes (quotient, then remainder),
// then walked through the years after 1970 and the months of its year; out-of-range sums skip
// straight to publishing; a new item is taken only after the last one is published; a result
// held by out_stall_i adds its wait once the next item is finished
// reset clears the controller, the output valid and reference_seconds (to zero)
module epoch_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] reference_seconds_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] counter_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  date_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [2:0]  weekday_o,
  output logic        out_of_range_o
);
  import es2c_pkg::*;

  es2c_cmd_t cmd;
  es2c_sts_t sts;

  assign cfg_ready_o = 1'b1;

  es2c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  es2c_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_data_i      (reference_seconds_i),
    .counter_value_i (counter_value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .year_o          (year_o),
    .month_o         (month_o),
    .date_o          (date_o),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o),
    .weekday_o       (weekday_o),
    .out_of_range_o  (out_of_range_o)
  );

`ifndef ASSERT_OFF
  // an accepted item keeps the input side busy for at least the next cycle
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a transfer");

  // out-of-range results carry all-zero calendar fields
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (year_o == 12'd0 && month_o == 4'd0 &&
      date_o == 5'd0 && hour_o == 5'd0 && minute_o == 6'd0 && second_o == 6'd0 &&
      weekday_o == 3'd0))
    else $error("out-of-range result with nonzero fields");

  // in-range results are legal calendar values
  a_fields_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_of_range_o) |-> (month_o >= 4'd1 && month_o <= 4'd12 &&
      date_o >= 5'd1 && hour_o <= 5'd23 && minute_o <= 6'd59 && second_o <= 6'd59 &&
      weekday_o <= 3'd6 && year_o >= 12'd1970 && year_o <= 12'd2099))
    else $error("result field outside its calendar range");
`endif

endmodule
